@@ design/tps_pkg.sv @@
package tps_pkg;

  typedef logic signed [31:0] coord_t;

  typedef struct packed {
    coord_t v0_x;
    coord_t v0_y;
    coord_t v0_z;
    coord_t v1_x;
    coord_t v1_y;
    coord_t v1_z;
    coord_t v2_x;
    coord_t v2_y;
    coord_t v2_z;
  } tri_t;

  typedef struct packed {
    logic   cut;
    coord_t seg_a_x;
    coord_t seg_a_y;
    coord_t seg_a_z;
    coord_t seg_b_x;
    coord_t seg_b_y;
    coord_t seg_b_z;
  } seg_t;

  localparam int unsigned CFG_IDX_W = 3;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          value;
  } cfg_req_t;

  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 3'd5;

  // plane value, magnitude, divisor, quotient, numerator and chunk widths; chunk and lane counts
  localparam int unsigned S_W     = 67;
  localparam int unsigned MAG_W   = 66;
  localparam int unsigned D_W     = 67;
  localparam int unsigned Q_W     = 32;
  localparam int unsigned NUM_W   = MAG_W + Q_W;
  localparam int unsigned CHUNK_W = 22;
  localparam int unsigned N_CHUNK = MAG_W / CHUNK_W;
  localparam int unsigned N_LANE  = 6;

  typedef struct packed {
    logic [D_W-1:0] rem;
    logic [D_W-1:0] den;
    logic [Q_W-1:0] nlo;
    logic [Q_W-1:0] quo;
    coord_t         pk;
    logic           negq;
  } lane_t;

  // one restoring division step, one quotient bit
  function automatic lane_t div_step(lane_t l);
    lane_t        r;
    logic [D_W:0] t;
    logic [D_W:0] diff;
    r    = l;
    t    = {l.rem, l.nlo[Q_W-1]};
    diff = t - {1'b0, l.den};
    if (!diff[D_W]) begin
      r.rem = diff[D_W-1:0];
      r.quo = {l.quo[Q_W-2:0], 1'b1};
    end else begin
      r.rem = t[D_W-1:0];
      r.quo = {l.quo[Q_W-2:0], 1'b0};
    end
    r.nlo = {l.nlo[Q_W-2:0], 1'b0};
    return r;
  endfunction

endpackage

@@ design/tps_if.sv @@
interface tps_tri_if;
  logic          valid;
  logic          ready;
  tps_pkg::tri_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface tps_seg_if;
  logic          valid;
  logic          ready;
  tps_pkg::seg_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface tps_cfg_if;
  logic              valid;
  logic              ready;
  tps_pkg::cfg_req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ design/triangle_plane_slice.sv @@
// channel  dir  request                         accepted when
// tri_i    in   three vertices, Q16.16          tri_i.valid & tri_i.ready
// seg_o    out  cut flag, two cut points        seg_o.valid & seg_o.ready
// cfg_i    in   register index, 32-bit value    cfg_i.valid & cfg_i.ready
//
// One triangle per cycle while the skid is empty; the path has 6 arithmetic stages,
// 32 divider stages of one quotient bit each, and an output register.
// rst_ni clears valid bits and loads plane registers with normal (0,0,1), center 0.
// A skid register behind the output keeps the pipeline moving while seg_o stalls
// until the skid fills; tri_i.ready is registered and drops only while it is full.
module triangle_plane_slice (
  input  logic         clk_i,
  input  logic         rst_ni,
  tps_tri_if.sink      tri_i,
  tps_seg_if.source    seg_o,
  tps_cfg_if.sink      cfg_i
);

  localparam int unsigned DIV_N = tps_pkg::Q_W;

  tps_pkg::coord_t nrm_q [3];
  tps_pkg::coord_t cen_q [3];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nrm_q[0] <= '0;
      nrm_q[1] <= '0;
      nrm_q[2] <= 32'sd65536;
      cen_q[0] <= '0;
      cen_q[1] <= '0;
      cen_q[2] <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        tps_pkg::REG_NORMAL_X: nrm_q[0] <= cfg_i.data.value;
        tps_pkg::REG_NORMAL_Y: nrm_q[1] <= cfg_i.data.value;
        tps_pkg::REG_NORMAL_Z: nrm_q[2] <= cfg_i.data.value;
        tps_pkg::REG_CENTER_X: cen_q[0] <= cfg_i.data.value;
        tps_pkg::REG_CENTER_Y: cen_q[1] <= cfg_i.data.value;
        tps_pkg::REG_CENTER_Z: cen_q[2] <= cfg_i.data.value;
        default: ;
      endcase
    end
  end

  logic adv;
  logic sv_q;
  assign adv         = !sv_q;
  assign tri_i.ready = adv;

  // stage 1: unpack, subtract center
  tps_pkg::coord_t   vin [3][3];
  tps_pkg::coord_t   v1_q [3][3];
  logic signed [32:0] dv1_q [3][3];
  logic               vld1_q;

  always_comb begin
    vin[0][0] = tri_i.data.v0_x; vin[0][1] = tri_i.data.v0_y; vin[0][2] = tri_i.data.v0_z;
    vin[1][0] = tri_i.data.v1_x; vin[1][1] = tri_i.data.v1_y; vin[1][2] = tri_i.data.v1_z;
    vin[2][0] = tri_i.data.v2_x; vin[2][1] = tri_i.data.v2_y; vin[2][2] = tri_i.data.v2_z;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int c = 0; c < 3; c++) begin
          v1_q[i][c]  <= vin[i][c];
          dv1_q[i][c] <= 33'(vin[i][c]) - 33'(cen_q[c]);
        end
      end
    end
  end

  // stage 2: products
  tps_pkg::coord_t    v2_q [3][3];
  logic signed [64:0] pr2_q [3][3];
  logic               vld2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int c = 0; c < 3; c++) begin
          v2_q[i][c]  <= v1_q[i][c];
          pr2_q[i][c] <= 65'(nrm_q[c]) * 65'(dv1_q[i][c]);
        end
      end
    end
  end

  // stage 3: plane values
  tps_pkg::coord_t               v3_q [3][3];
  logic signed [tps_pkg::S_W-1:0] s3_q [3];
  logic                           vld3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int c = 0; c < 3; c++) v3_q[i][c] <= v2_q[i][c];
        s3_q[i] <= tps_pkg::S_W'(pr2_q[i][0]) + tps_pkg::S_W'(pr2_q[i][1])
                 + tps_pkg::S_W'(pr2_q[i][2]);
      end
    end
  end

  // stage 4: classify, pick lone vertex, form operands
  logic [1:0] sg [3];
  logic       cut_c;
  logic [1:0] k_c;
  logic [1:0] tj [2];

  logic [tps_pkg::MAG_W-1:0] mag4_q [2];
  logic [tps_pkg::Q_W-1:0]   dmag4_q [tps_pkg::N_LANE];
  logic [tps_pkg::D_W-1:0]   den4_q [tps_pkg::N_LANE];
  tps_pkg::coord_t           pk4_q [tps_pkg::N_LANE];
  logic                      neg4_q [tps_pkg::N_LANE];
  logic                      cut4_q;
  logic                      vld4_q;

  logic signed [tps_pkg::S_W-1:0] sk_c;
  logic signed [tps_pkg::S_W:0]   den_c [2];
  logic signed [tps_pkg::S_W-1:0] ska_c;
  logic signed [32:0]             d_c [tps_pkg::N_LANE];

  always_comb begin
    for (int i = 0; i < 3; i++) sg[i] = {s3_q[i][tps_pkg::S_W-1], |s3_q[i]};
    cut_c = (sg[0][1] | sg[1][1] | sg[2][1]) &
            ((sg[0] == 2'b01) | (sg[1] == 2'b01) | (sg[2] == 2'b01));
    if (sg[0] != sg[1] && sg[0] != sg[2]) begin
      k_c = 2'd0; tj[0] = 2'd2; tj[1] = 2'd1;
    end else if (sg[1] != sg[0] && sg[1] != sg[2]) begin
      k_c = 2'd1; tj[0] = 2'd2; tj[1] = 2'd0;
    end else begin
      k_c = 2'd2; tj[0] = 2'd0; tj[1] = 2'd1;
    end
    sk_c  = s3_q[k_c];
    ska_c = sk_c[tps_pkg::S_W-1] ? -sk_c : sk_c;
    for (int p = 0; p < 2; p++) begin
      den_c[p] = (tps_pkg::S_W+1)'(s3_q[tj[p]]) - (tps_pkg::S_W+1)'(sk_c);
      for (int c = 0; c < 3; c++) begin
        d_c[p*3+c] = 33'(v3_q[tj[p]][c]) - 33'(v3_q[k_c][c]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cut4_q <= cut_c;
      for (int p = 0; p < 2; p++) begin
        mag4_q[p] <= ska_c[tps_pkg::MAG_W-1:0];
        for (int c = 0; c < 3; c++) begin
          dmag4_q[p*3+c] <= d_c[p*3+c][32] ? 32'(-d_c[p*3+c]) : d_c[p*3+c][31:0];
          den4_q[p*3+c]  <= den_c[p][tps_pkg::S_W] ?
                            tps_pkg::D_W'(-den_c[p]) : den_c[p][tps_pkg::D_W-1:0];
          pk4_q[p*3+c]   <= v3_q[k_c][c];
          neg4_q[p*3+c]  <= (sk_c[tps_pkg::S_W-1] ^ d_c[p*3+c][32]) ^ den_c[p][tps_pkg::S_W];
        end
      end
    end
  end

  // stage 5: partial products of |s_k| * |delta|
  localparam int unsigned PP_W = tps_pkg::CHUNK_W + tps_pkg::Q_W;
  logic [PP_W-1:0]         pp5_q [tps_pkg::N_LANE][tps_pkg::N_CHUNK];
  logic [tps_pkg::D_W-1:0] den5_q [tps_pkg::N_LANE];
  tps_pkg::coord_t         pk5_q [tps_pkg::N_LANE];
  logic                    neg5_q [tps_pkg::N_LANE];
  logic                    cut5_q;
  logic                    vld5_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cut5_q <= cut4_q;
      for (int l = 0; l < tps_pkg::N_LANE; l++) begin
        den5_q[l] <= den4_q[l];
        pk5_q[l]  <= pk4_q[l];
        neg5_q[l] <= neg4_q[l];
        for (int h = 0; h < tps_pkg::N_CHUNK; h++) begin
          pp5_q[l][h] <= PP_W'(mag4_q[l/3][h*tps_pkg::CHUNK_W +: tps_pkg::CHUNK_W])
                         * PP_W'(dmag4_q[l]);
        end
      end
    end
  end

  // stage 6: numerator, divider setup
  tps_pkg::lane_t dl_q [DIV_N+1][tps_pkg::N_LANE];
  logic           dcut_q [DIV_N+1];
  logic           dvld_q [DIV_N+1];
  logic [tps_pkg::NUM_W-1:0] num_c [tps_pkg::N_LANE];

  always_comb begin
    for (int l = 0; l < tps_pkg::N_LANE; l++) begin
      num_c[l] = '0;
      for (int h = 0; h < tps_pkg::N_CHUNK; h++) begin
        num_c[l] = num_c[l] + (tps_pkg::NUM_W'(pp5_q[l][h]) << (h * tps_pkg::CHUNK_W));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dcut_q[0] <= cut5_q;
      for (int l = 0; l < tps_pkg::N_LANE; l++) begin
        dl_q[0][l].rem  <= tps_pkg::D_W'(num_c[l][tps_pkg::NUM_W-1:tps_pkg::Q_W]);
        dl_q[0][l].nlo  <= num_c[l][tps_pkg::Q_W-1:0];
        dl_q[0][l].quo  <= '0;
        dl_q[0][l].den  <= den5_q[l];
        dl_q[0][l].pk   <= pk5_q[l];
        dl_q[0][l].negq <= neg5_q[l];
      end
    end
  end

  for (genvar j = 0; j < DIV_N; j++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dcut_q[j+1] <= dcut_q[j];
        for (int l = 0; l < tps_pkg::N_LANE; l++) dl_q[j+1][l] <= tps_pkg::div_step(dl_q[j][l]);
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dvld_q[j+1] <= 1'b0;
      else if (adv) dvld_q[j+1] <= dvld_q[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q    <= 1'b0;
      vld2_q    <= 1'b0;
      vld3_q    <= 1'b0;
      vld4_q    <= 1'b0;
      vld5_q    <= 1'b0;
      dvld_q[0] <= 1'b0;
    end else if (adv) begin
      vld1_q    <= tri_i.valid;
      vld2_q    <= vld1_q;
      vld3_q    <= vld2_q;
      vld4_q    <= vld3_q;
      vld5_q    <= vld4_q;
      dvld_q[0] <= vld5_q;
    end
  end

  // final: apply quotient, saturate, zero when no cut
  tps_pkg::coord_t res_c [tps_pkg::N_LANE];
  logic signed [33:0] sum_c [tps_pkg::N_LANE];
  tps_pkg::seg_t pd;
  logic          pv;

  always_comb begin
    for (int l = 0; l < tps_pkg::N_LANE; l++) begin
      sum_c[l] = dl_q[DIV_N][l].negq ?
                 34'(dl_q[DIV_N][l].pk) + 34'({1'b0, dl_q[DIV_N][l].quo}) :
                 34'(dl_q[DIV_N][l].pk) - 34'({1'b0, dl_q[DIV_N][l].quo});
      if (sum_c[l] > 34'sh0_7FFF_FFFF) res_c[l] = 32'sh7FFF_FFFF;
      else if (sum_c[l] < -34'sh0_8000_0000) res_c[l] = 32'sh8000_0000;
      else res_c[l] = sum_c[l][31:0];
      if (!dcut_q[DIV_N]) res_c[l] = '0;
    end
    pd.cut     = dcut_q[DIV_N];
    pd.seg_a_x = res_c[0];
    pd.seg_a_y = res_c[1];
    pd.seg_a_z = res_c[2];
    pd.seg_b_x = res_c[3];
    pd.seg_b_y = res_c[4];
    pd.seg_b_z = res_c[5];
    pv         = dvld_q[DIV_N];
  end

  // output register and skid
  tps_pkg::seg_t od_q, sd_q;
  logic          ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else if (ov_q && !seg_o.ready) begin
      if (adv && pv) begin
        sv_q <= 1'b1;
        sd_q <= pd;
      end
    end else if (sv_q) begin
      od_q <= sd_q;
      ov_q <= 1'b1;
      sv_q <= 1'b0;
    end else begin
      ov_q <= pv;
      if (pv) od_q <= pd;
    end
  end

  assign seg_o.valid = ov_q;
  assign seg_o.data  = od_q;

endmodule
